// ===== rtl/mnp_pkg.sv =====
// Shared constants and control types for the multiset next-permutation core.
package mnp_pkg;

  // Port widths fixed by the interface
  localparam int FUNC_W = 2;
  localparam int POS_W  = 6;
  localparam int SYM_W  = 3;
  localparam int STAT_W = 2;

  // Input word operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

  // Result word status codes
  localparam logic [STAT_W-1:0] STAT_LOADED   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ADVANCED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LAST     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_READ     = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // latch the input word, clear per-item flags
    logic scan;     // rotate once, search for pivot and successor
    logic rewrite;  // rotate once, write new cells, check ordering
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_step;  // the current rotation step is the final one
    logic is_last;    // arrangement is non-increasing
  } dp_stat_t;

endpackage

// ===== rtl/mnp_dp.sv =====
// Datapath: rotating cell ring, reversal stack, pivot search and order check.
module mnp_dp import mnp_pkg::*; #(
  parameter int CELLS       = 20,
  parameter int SYMBOL_BITS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [POS_W-1:0]  in_position,
  input  logic [SYM_W-1:0]  in_symbol_in,
  output dp_stat_t          stat,
  output logic [SYM_W-1:0]  sym_out
);

  localparam int IDX_W = $clog2(CELLS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);

  typedef logic [SYMBOL_BITS-1:0] sym_t;

  sym_t              ring_r  [CELLS];
  sym_t              stack_r [CELLS];
  logic [IDX_W-1:0]  k_r;
  logic [FUNC_W-1:0] func_r;
  logic [POS_W-1:0]  pos_r;
  sym_t              sym_r;
  logic              found_r;
  logic [IDX_W-1:0]  pivot_r;
  logic [IDX_W-1:0]  succ_r;
  sym_t              pv_r;
  sym_t              sv_r;
  logic [IDX_W-1:0]  pop_idx_r;
  sym_t              prev_r;
  logic              asc_r;
  logic              is_last_r;
  sym_t              sym_out_r;

  sym_t head;
  sym_t top;
  sym_t nv;
  logic at_pos;
  logic scan_asc;
  logic step_asc;

  assign head   = ring_r[0];
  assign top    = stack_r[0];
  assign at_pos = (POS_W'(k_r) == pos_r);

  // New value for the cell now leaving the head of the ring
  always_comb begin
    case (func_r)
      FUNC_LOAD:    nv = at_pos ? sym_r : head;
      FUNC_ADVANCE: begin
        if (k_r < pivot_r)       nv = head;
        else if (k_r == pivot_r) nv = sv_r;
        else                     nv = (pop_idx_r == succ_r) ? pv_r : top;
      end
      default:      nv = head;
    endcase
  end

  assign scan_asc = (k_r != '0) && (prev_r < head);
  assign step_asc = (k_r != '0) && (prev_r < nv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) ring_r[i] <= '0;
      k_r       <= '0;
      found_r   <= 1'b0;
      asc_r     <= 1'b0;
      is_last_r <= 1'b1;
      sym_out_r <= '0;
    end else begin
      if (cmd.accept) begin
        func_r    <= in_func;
        pos_r     <= in_position;
        sym_r     <= SYMBOL_BITS'(in_symbol_in);
        k_r       <= '0;
        found_r   <= 1'b0;
        asc_r     <= 1'b0;
        sym_out_r <= '0;
        pop_idx_r <= LAST_IDX;
      end

      if (cmd.scan || cmd.rewrite) begin
        k_r <= (k_r == LAST_IDX) ? '0 : k_r + 1'b1;
        for (int i = 0; i < CELLS - 1; i++) ring_r[i] <= ring_r[i+1];
      end

      if (cmd.scan) begin
        // recirculate unchanged, push a copy for the later reversal
        ring_r[CELLS-1] <= head;
        stack_r[0]      <= head;
        for (int i = 1; i < CELLS; i++) stack_r[i] <= stack_r[i-1];
        prev_r <= head;
        if (scan_asc) begin
          found_r <= 1'b1;
          pivot_r <= k_r - 1'b1;
          pv_r    <= prev_r;
          succ_r  <= k_r;
          sv_r    <= head;
        end else if (found_r && (head > pv_r)) begin
          succ_r <= k_r;
          sv_r   <= head;
        end
      end

      if (cmd.rewrite) begin
        ring_r[CELLS-1] <= nv;
        prev_r          <= nv;
        if (step_asc) asc_r <= 1'b1;
        if ((func_r == FUNC_ADVANCE) && (k_r > pivot_r)) begin
          for (int i = 0; i < CELLS - 1; i++) stack_r[i] <= stack_r[i+1];
          pop_idx_r <= pop_idx_r - 1'b1;
        end
        if ((func_r == FUNC_READ) && at_pos) sym_out_r <= head;
        if (k_r == LAST_IDX) is_last_r <= !(asc_r || step_asc);
      end
    end
  end

  assign stat.last_step = (k_r == LAST_IDX);
  assign stat.is_last   = is_last_r;
  assign sym_out        = SYM_W'(sym_out_r);

endmodule

// ===== rtl/mnp_ctrl.sv =====
// Controller: sequences scan and rewrite passes and issues the result strobe.
module mnp_ctrl import mnp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FUNC_W-1:0] in_func,
  output logic              busy,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output dp_cmd_t           cmd,
  input  dp_stat_t          stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REWRITE
  } state_t;

  state_t            state_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] stat_code_r;

  assign busy        = (state_r != S_IDLE);
  assign cmd.accept  = start && (state_r == S_IDLE);
  assign cmd.scan    = (state_r == S_SCAN);
  assign cmd.rewrite = (state_r == S_REWRITE);
  assign out_valid   = out_valid_r;
  assign out_status  = stat_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      stat_code_r <= STAT_LOADED;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_func == FUNC_ADVANCE) begin
              if (stat.is_last) begin
                // nothing to step: answer at once
                out_valid_r <= 1'b1;
                stat_code_r <= STAT_LAST;
              end else begin
                state_r     <= S_SCAN;
                stat_code_r <= STAT_ADVANCED;
              end
            end else begin
              state_r     <= S_REWRITE;
              stat_code_r <= (in_func == FUNC_LOAD) ? STAT_LOADED : STAT_READ;
            end
          end
        end
        S_SCAN: begin
          if (stat.last_step) state_r <= S_REWRITE;
        end
        S_REWRITE: begin
          if (stat.last_step) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/multiset_next_permutation_core.sv =====
// Top level of the multiset next-permutation core.
//
// The core keeps an arrangement of CELLS symbols (SYMBOL_BITS each, repeats
// allowed, all zero after reset) in a ring of registers that rotates one
// cell per clock while busy. A word is taken on a rising edge with start
// high and busy low. A load (func 0) writes in_symbol_in at in_position, a
// read (func 2) returns the cell at in_position, and an advance (func 1)
// steps the arrangement to its next lexicographic permutation; func 3 and
// positions at or beyond CELLS change nothing. Every word yields exactly
// one result: the out_valid strobe is high for a single cycle with
// out_symbol_out, out_status and out_is_last, and the receiver cannot stall
// it, so capture it on that cycle. Load, read and func 3 make one full ring
// rotation, then give the strobe; an advance makes a search rotation for
// pivot and successor, then a rewrite rotation that swaps and reverses the
// suffix through a register stack; an advance on an arrangement that is
// already last answers straight from the idle state with status 2, with no
// rotation. busy drops with the strobe, so the next word may be taken on
// the edge that ends it.
module multiset_next_permutation_core import mnp_pkg::*; #(
  parameter int CELLS       = 20,
  parameter int SYMBOL_BITS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [POS_W-1:0]  in_position,
  input  logic [SYM_W-1:0]  in_symbol_in,
  output logic              out_valid,
  output logic [SYM_W-1:0]  out_symbol_out,
  output logic [STAT_W-1:0] out_status,
  output logic              out_is_last
);

  dp_cmd_t  cmd;
  dp_stat_t dp_stat;

  // Sequence the passes and own the handshake
  mnp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_func    (in_func),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_status (out_status),
    .cmd        (cmd),
    .stat       (dp_stat)
  );

  // Hold the arrangement and do the per-cell work
  mnp_dp #(
    .CELLS       (CELLS),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_func      (in_func),
    .in_position  (in_position),
    .in_symbol_in (in_symbol_in),
    .stat         (dp_stat),
    .sym_out      (out_symbol_out)
  );

  // The flag stays valid between words; sample it with the strobe
  assign out_is_last = dp_stat.is_last;

endmodule

// ===== rtl/mnp_checker.sv =====
// Port-level checker for the multiset next-permutation core, with its bind.
module mnp_checker import mnp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [FUNC_W-1:0] in_func,
  input logic              out_valid,
  input logic [SYM_W-1:0]  out_symbol_out,
  input logic [STAT_W-1:0] out_status,
  input logic              out_is_last
);

  // An unchanged advance only happens on a last arrangement
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_LAST) |-> out_is_last)
    else $error("status last without is_last");

  // Only a read returns a symbol
  a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_READ) |-> (out_symbol_out == '0))
    else $error("symbol on a non-read word");

  // A result word is delivered only once the core is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("strobe while busy");

  // Work begins only from an accepted word
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without start");

  // An advance on a last arrangement, accepted in a strobe cycle, answers on the next cycle
  a_last_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_func == FUNC_ADVANCE) && out_valid && out_is_last
    |=> out_valid && (out_status == STAT_LAST))
    else $error("advance on last arrangement not answered at once");

endmodule

bind multiset_next_permutation_core mnp_checker u_mnp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_symbol_out (out_symbol_out),
  .out_status     (out_status),
  .out_is_last    (out_is_last)
);
